@@ rtl/pfa_pkg.sv @@
package pfa_pkg;

	typedef struct packed {
		logic       used;
		logic [7:0] pid;
	} owner_t;

	typedef struct packed {
		logic        start;
		logic [32:0] num;
		logic [16:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [33:0] quot;
	} div_rsp_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_NOPROC  = 2'd2;

	localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
	localparam logic [1:0] CFG_PAGE_SIZE   = 2'd1;

	localparam logic [6:0]  FRAME_COUNT_RST = 7'd64;
	localparam logic [16:0] PAGE_SIZE_RST   = 17'd4096;

endpackage

@@ rtl/pfa_div.sv @@
module pfa_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pfa_pkg::div_req_t  req,
	output pfa_pkg::div_rsp_t  rsp
);

	localparam logic [4:0] LAST_STEP = 5'd16;

	logic [33:0] num_q;
	logic [33:0] quot_q;
	logic [16:0] rem_q;
	logic [16:0] den_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;

	logic [17:0] r1, r2;
	logic [16:0] r1s, r2s;
	logic        ge1, ge2;

	// two restoring steps per cycle
	always_comb begin
		r1  = {rem_q, num_q[33]};
		ge1 = r1 >= {1'b0, den_q};
		r1s = ge1 ? 17'(r1 - {1'b0, den_q}) : r1[16:0];
		r2  = {r1s, num_q[32]};
		ge2 = r2 >= {1'b0, den_q};
		r2s = ge2 ? 17'(r2 - {1'b0, den_q}) : r2[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quot_q <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				cnt_q  <= '0;
				num_q  <= {1'b0, req.num};
				den_q  <= req.den;
				rem_q  <= '0;
				quot_q <= '0;
			end else if (run_q) begin
				num_q  <= {num_q[31:0], 2'b00};
				quot_q <= {quot_q[31:0], ge1, ge2};
				rem_q  <= r2s;
				cnt_q  <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ rtl/pfa_owner_mem.sv @@
module pfa_owner_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  pfa_pkg::owner_t   wdata,
	input  logic [AW-1:0]     raddr,
	output pfa_pkg::owner_t   rdata
);

	pfa_pkg::owner_t mem [DEPTH];
	pfa_pkg::owner_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/pfa_known_mem.sv @@
module pfa_known_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/paged_frame_allocator.sv @@
// First-fit page frame allocator.
// Requests: start/busy command channel (op, pid, process_size); a request is
// taken on a clock edge with start high and busy low.
// Results: one-cycle strobe result_valid with status, frame_valid, frame, last.
// The receiver cannot hold results off; every request ends with last high.
// Allocate: the request is taken, the page count is worked out in the
// 2-bit-per-cycle divider, then one frame store read per cycle from frame 0
// upward, one result per frame granted.
// Free: a process table lookup, then a pass over min(NUM_FRAMES, 64) frame
// entries. Unknown or out-of-range pid and no-space results end the request
// without a frame pass.
// Config: cfg_valid/cfg_ready write channel, always ready. Writing frame_count
// while idle, recounting or ending the reset pass starts a recount pass over
// the frames in use with busy high.
// Reset: both stores are cleared by a pass over max(min(NUM_FRAMES, 64),
// PID_COUNT) entries, 256 with default parameters, during which busy is high.
module paged_frame_allocator #(
	parameter int NUM_FRAMES = 64,
	parameter int PID_COUNT  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [7:0]  pid,
	input  logic [31:0] process_size,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output logic        result_valid,
	output logic [1:0]  status,
	output logic        frame_valid,
	output logic [5:0]  frame,
	output logic        last
);

	localparam int FRAMES_USED = (NUM_FRAMES < 64) ? NUM_FRAMES : 64;
	localparam int FA          = (FRAMES_USED > 1) ? $clog2(FRAMES_USED) : 1;
	localparam int KA          = $clog2(PID_COUNT);
	localparam int CLR_N       = (FRAMES_USED > PID_COUNT) ? FRAMES_USED : PID_COUNT;
	localparam int IW0         = $clog2(CLR_N + 1);
	localparam int IW          = (IW0 > 7) ? IW0 : 7;

	localparam logic [6:0]    FU7      = 7'(FRAMES_USED);
	localparam logic [IW-1:0] CLR_LAST = IW'(CLR_N - 1);
	localparam logic [IW-1:0] FU_IW    = IW'(FRAMES_USED);
	localparam logic [IW-1:0] PC_IW    = IW'(PID_COUNT);

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_DIV     = 3'd2;
	localparam logic [2:0] S_ALLOC   = 3'd3;
	localparam logic [2:0] S_FCHK    = 3'd4;
	localparam logic [2:0] S_FREE    = 3'd5;
	localparam logic [2:0] S_RECOUNT = 3'd6;

	logic [2:0]    state_q;
	logic [IW-1:0] idx_q;
	logic          vld_s1;
	logic [6:0]    addr_s1;
	logic [6:0]    free_q;
	logic [6:0]    need_q;
	logic [7:0]    pid_q;
	logic [6:0]    frame_count_q;
	logic [16:0]   page_size_q;

	logic          res_q;
	logic [1:0]    status_q;
	logic          fv_q;
	logic [5:0]    frame_q;
	logic          last_q;

	pfa_pkg::div_req_t div_req;
	pfa_pkg::div_rsp_t div_rsp;

	logic            owner_we;
	logic [FA-1:0]   owner_waddr;
	pfa_pkg::owner_t owner_wdata;
	pfa_pkg::owner_t owner_rdata;
	logic            known_we;
	logic [KA-1:0]   known_waddr;
	logic            known_wdata;
	logic            known_rdata;

	logic [6:0]    n_eff;
	logic [IW-1:0] limit;
	logic          scanning;
	logic          scan_on;
	logic          scan_end;
	logic          clear_end;
	logic          pid_bad;
	logic          accept;
	logic          cfg_fc_wr;
	logic          hit_alloc;
	logic          hit_free;
	logic          fits;
	logic [16:0]   den;

	assign n_eff     = (frame_count_q > FU7) ? FU7 : frame_count_q;
	assign limit     = (state_q == S_FREE) ? FU_IW : IW'(n_eff);
	assign scanning  = (state_q == S_ALLOC) || (state_q == S_FREE) || (state_q == S_RECOUNT);
	assign scan_on   = scanning && (idx_q < limit);
	assign scan_end  = !scan_on && !vld_s1;
	assign clear_end = (state_q == S_CLEAR) && (idx_q == CLR_LAST);
	assign pid_bad   = ({24'd0, pid} >= 32'(PID_COUNT));
	assign accept    = start && !busy;
	assign cfg_fc_wr = cfg_valid && (cfg_index == pfa_pkg::CFG_FRAME_COUNT);
	assign hit_alloc = (state_q == S_ALLOC) && vld_s1 && !owner_rdata.used;
	assign hit_free  = (state_q == S_FREE) && vld_s1 && owner_rdata.used
		&& (owner_rdata.pid == pid_q);
	assign fits      = div_rsp.quot <= {27'd0, free_q};
	assign den       = (page_size_q == 17'd0) ? 17'd1 : page_size_q;

	assign div_req.start = accept && !pid_bad && (op == pfa_pkg::OP_ALLOC);
	assign div_req.num   = 33'({1'b0, process_size} + {16'd0, den} - 33'd1);
	assign div_req.den   = den;

	always_comb begin
		owner_we    = 1'b0;
		owner_waddr = addr_s1[FA-1:0];
		owner_wdata = '0;
		known_we    = 1'b0;
		known_waddr = KA'(pid_q);
		known_wdata = 1'b0;
		case (state_q)
			S_CLEAR: begin
				owner_we    = idx_q < FU_IW;
				owner_waddr = idx_q[FA-1:0];
				known_we    = idx_q < PC_IW;
				known_waddr = idx_q[KA-1:0];
			end
			S_DIV: begin
				known_we    = div_rsp.done && fits;
				known_wdata = 1'b1;
			end
			S_ALLOC: begin
				owner_we    = hit_alloc;
				owner_wdata = '{used: 1'b1, pid: pid_q};
			end
			S_FREE: begin
				owner_we = hit_free;
				known_we = scan_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			idx_q         <= '0;
			vld_s1        <= 1'b0;
			addr_s1       <= '0;
			free_q        <= '0;
			need_q        <= '0;
			pid_q         <= '0;
			frame_count_q <= pfa_pkg::FRAME_COUNT_RST;
			page_size_q   <= pfa_pkg::PAGE_SIZE_RST;
			res_q         <= 1'b0;
			status_q      <= pfa_pkg::ST_OK;
			fv_q          <= 1'b0;
			frame_q       <= '0;
			last_q        <= 1'b0;
		end else begin
			res_q  <= 1'b0;
			vld_s1 <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == pfa_pkg::CFG_FRAME_COUNT) begin
					frame_count_q <= cfg_data[6:0];
				end else if (cfg_index == pfa_pkg::CFG_PAGE_SIZE) begin
					page_size_q <= cfg_data;
				end
			end
			if (scanning) begin
				vld_s1  <= scan_on;
				addr_s1 <= idx_q[6:0];
				if (scan_on) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + IW'(1);
					if (clear_end) begin
						idx_q   <= '0;
						free_q  <= n_eff;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						pid_q <= pid;
						if (pid_bad) begin
							res_q    <= 1'b1;
							status_q <= pfa_pkg::ST_NOPROC;
							fv_q     <= 1'b0;
							frame_q  <= '0;
							last_q   <= 1'b1;
						end else if (op == pfa_pkg::OP_ALLOC) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_FCHK;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (!fits) begin
							res_q    <= 1'b1;
							status_q <= pfa_pkg::ST_NOSPACE;
							fv_q     <= 1'b0;
							frame_q  <= '0;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else if (div_rsp.quot == 34'd0) begin
							res_q    <= 1'b1;
							status_q <= pfa_pkg::ST_OK;
							fv_q     <= 1'b0;
							frame_q  <= '0;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							need_q  <= div_rsp.quot[6:0];
							idx_q   <= '0;
							state_q <= S_ALLOC;
						end
					end
				end
				S_ALLOC: begin
					if (hit_alloc) begin
						res_q    <= 1'b1;
						status_q <= pfa_pkg::ST_OK;
						fv_q     <= 1'b1;
						frame_q  <= addr_s1[5:0];
						last_q   <= (need_q == 7'd1);
						need_q   <= need_q - 7'd1;
						free_q   <= free_q - 7'd1;
						if (need_q == 7'd1) begin
							state_q <= S_IDLE;
						end
					end else if (scan_end) begin
						state_q <= S_IDLE;
					end
				end
				S_FCHK: begin
					if (!known_rdata) begin
						res_q    <= 1'b1;
						status_q <= pfa_pkg::ST_NOPROC;
						fv_q     <= 1'b0;
						frame_q  <= '0;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						idx_q   <= '0;
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					if (hit_free && (addr_s1 < n_eff)) begin
						free_q <= free_q + 7'd1;
					end
					if (scan_end) begin
						res_q    <= 1'b1;
						status_q <= pfa_pkg::ST_OK;
						fv_q     <= 1'b0;
						frame_q  <= '0;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_RECOUNT: begin
					if (vld_s1 && !owner_rdata.used) begin
						free_q <= free_q + 7'd1;
					end
					if (scan_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// frame_count change while idle, recounting or ending the reset pass: recount free frames in use
			if (cfg_fc_wr && (state_q == S_IDLE || state_q == S_RECOUNT || clear_end)) begin
				state_q <= S_RECOUNT;
				idx_q   <= '0;
				free_q  <= '0;
				vld_s1  <= 1'b0;
			end
		end
	end

	pfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pfa_owner_mem #(
		.DEPTH (FRAMES_USED),
		.AW    (FA)
	) u_owner_mem (
		.clk   (clk),
		.we    (owner_we),
		.waddr (owner_waddr),
		.wdata (owner_wdata),
		.raddr (idx_q[FA-1:0]),
		.rdata (owner_rdata)
	);

	pfa_known_mem #(
		.DEPTH (PID_COUNT),
		.AW    (KA)
	) u_known_mem (
		.clk   (clk),
		.we    (known_we),
		.waddr (known_waddr),
		.wdata (known_wdata),
		.raddr (KA'(pid)),
		.rdata (known_rdata)
	);

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_q;
	assign status       = status_q;
	assign frame_valid  = fv_q;
	assign frame        = frame_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_valid |-> status == pfa_pkg::ST_OK)
		else $error("frame result with non-ok status");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !frame_valid |-> last)
		else $error("frameless result not marked last");

	a_alloc_need: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ALLOC |-> need_q != 7'd0)
		else $error("allocation scan with nothing left to grant");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside page count state");
`endif

endmodule

@@ test/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NFRAMES = 64;
	localparam int NPIDS = 256;
	localparam int PG = int'(pfa_pkg::PAGE_SIZE_RST);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 36;
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;

	typedef struct {
		logic        op;
		logic [7:0]  pid;
		logic [31:0] size;
	} request_t;

	typedef struct packed {
		logic [1:0] status;
		logic       frame_valid;
		logic [5:0] frame;
		logic       last;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        op = pfa_pkg::OP_ALLOC;
	logic [7:0]  pid = '0;
	logic [31:0] process_size = '0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = pfa_pkg::CFG_FRAME_COUNT;
	logic [16:0] cfg_data = '0;
	logic        busy;
	logic        cfg_ready;
	logic        result_valid;
	logic [1:0]  status;
	logic        frame_valid;
	logic [5:0]  frame;
	logic        last;

	request_t        request_q[$];
	grant_t          grant_q[$];
	pfa_pkg::owner_t owner_tbl[NFRAMES];
	logic            pid_live[NPIDS];
	logic [6:0]      frame_count_reg = pfa_pkg::FRAME_COUNT_RST;
	logic [16:0]     page_size_reg = pfa_pkg::PAGE_SIZE_RST;

	bit offering = 1'b0;
	bit no_gaps = 1'b0;
	int gap_left = 0;
	int quiet_cycles = 0;
	int n_errors = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_granted = 0;
	int n_nospace = 0;
	int n_noproc = 0;
	int n_cfg = 0;

	paged_frame_allocator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.pid         (pid),
		.process_size(process_size),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.status      (status),
		.frame_valid (frame_valid),
		.frame       (frame),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < NFRAMES; i++) owner_tbl[i] = '0;
		for (int i = 0; i < NPIDS; i++) pid_live[i] = 1'b0;
	end

	function automatic void add_grant(grant_t g);
		grant_q = {grant_q, g};
	endfunction

	// first-fit allocation and release on the local copy of the frame table
	function automatic void allocate_or_release(request_t rq);
		int n_use;
		int n_free;
		longint unsigned pg;
		longint unsigned need;
		n_use = (frame_count_reg > NFRAMES) ? NFRAMES : int'(frame_count_reg);
		n_free = 0;
		for (int i = 0; i < n_use; i++) if (!owner_tbl[i].used) n_free++;
		if (rq.op == pfa_pkg::OP_ALLOC) begin
			pg = (page_size_reg == 0) ? 64'd1 : 64'(page_size_reg);
			need = (64'(rq.size) + pg - 64'd1) / pg;
			if (need > 64'(n_free)) begin
				n_nospace++;
				add_grant('{pfa_pkg::ST_NOSPACE, 1'b0, 6'd0, 1'b1});
			end else begin
				pid_live[rq.pid] = 1'b1;
				if (need == 0) begin
					add_grant('{pfa_pkg::ST_OK, 1'b0, 6'd0, 1'b1});
				end else begin
					for (int i = 0; i < n_use && need > 0; i++) begin
						if (!owner_tbl[i].used) begin
							owner_tbl[i] = '{1'b1, rq.pid};
							need--;
							n_granted++;
							add_grant('{pfa_pkg::ST_OK, 1'b1, 6'(i), 1'(need == 0)});
						end
					end
				end
			end
		end else if (!pid_live[rq.pid]) begin
			n_noproc++;
			add_grant('{pfa_pkg::ST_NOPROC, 1'b0, 6'd0, 1'b1});
		end else begin
			for (int i = 0; i < NFRAMES; i++)
				if (owner_tbl[i].used && owner_tbl[i].pid == rq.pid) owner_tbl[i] = '0;
			pid_live[rq.pid] = 1'b0;
			add_grant('{pfa_pkg::ST_OK, 1'b0, 6'd0, 1'b1});
		end
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	function automatic void queue_request(logic o, logic [7:0] p, logic [31:0] s);
		request_t rq;
		rq.op = o;
		rq.pid = p;
		rq.size = s;
		request_q = {request_q, rq};
	endfunction

	function automatic logic [31:0] bytes_for_pages(int pages, int bytes_per_page);
		if (pages == 0) return '0;
		return 32'((pages - 1) * bytes_per_page + int'($urandom_range(1, bytes_per_page)));
	endfunction

	always @(posedge clk) begin : driver
		request_t rq;
		rq.op = op;
		rq.pid = pid;
		rq.size = process_size;
		if (start && busy === 1'b0) begin
			allocate_or_release(rq);
			n_requests++;
			offering = 1'b0;
			gap_left = no_gaps ? 0 : int'($urandom_range(0, 15));
		end
		if (!offering && arst_n) begin
			if (gap_left > 0) begin
				if (busy === 1'b0) gap_left--;
			end else if (request_q.size() > 0) begin
				rq = request_q.pop_front();
				op <= rq.op;
				pid <= rq.pid;
				process_size <= rq.size;
				offering = 1'b1;
			end
		end
		start <= offering;
	end

	always @(posedge clk) begin : monitor
		grant_t want;
		if (result_valid) begin
			n_results++;
			if (grant_q.size() == 0) begin
				n_errors++;
				$display("%0t: result with none expected, got status %0d frame_valid %0d",
					$time, status, frame_valid);
				$display("%0t: frame %0d last %0d", $time, frame, last);
			end else begin
				want = grant_q.pop_front();
				check_field("status", 8'(want.status), 8'(status));
				check_field("frame_valid", 8'(want.frame_valid), 8'(frame_valid));
				check_field("frame", 8'(want.frame), 8'(frame));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((start && busy === 1'b0) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic wait_idle();
		do @(posedge clk);
		while (request_q.size() != 0 || offering || grant_q.size() != 0 || busy !== 1'b0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		n_cfg++;
		if (idx == pfa_pkg::CFG_FRAME_COUNT) frame_count_reg = val[6:0];
		else if (idx == pfa_pkg::CFG_PAGE_SIZE) page_size_reg = val;
	endtask

	initial begin : stimulus
		logic [7:0] pool[8];
		logic [7:0] who;
		int fc;
		int psz;
		int ps_eff;
		int r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// directed, reset configuration
		queue_request(pfa_pkg::OP_FREE, 8'd0, '0);
		queue_request(pfa_pkg::OP_ALLOC, 8'd0, '0);
		queue_request(pfa_pkg::OP_FREE, 8'd0, 32'hFFFF_FFFF);
		queue_request(pfa_pkg::OP_ALLOC, 8'd255, 32'd1);
		queue_request(pfa_pkg::OP_ALLOC, 8'd17, 32'(PG));
		queue_request(pfa_pkg::OP_ALLOC, 8'd17, 32'(PG + 1));  // live pid gets more frames
		queue_request(pfa_pkg::OP_ALLOC, 8'd200, 32'hFFFF_FFFF);
		queue_request(pfa_pkg::OP_FREE, 8'd17, '0);
		queue_request(pfa_pkg::OP_ALLOC, 8'd42, 32'(3 * PG));
		queue_request(pfa_pkg::OP_ALLOC, 8'd128, 32'(60 * PG));
		queue_request(pfa_pkg::OP_ALLOC, 8'd9, 32'd1);
		queue_request(pfa_pkg::OP_ALLOC, 8'd9, '0);
		queue_request(pfa_pkg::OP_FREE, 8'd128, '0);
		queue_request(pfa_pkg::OP_FREE, 8'd255, '0);
		queue_request(pfa_pkg::OP_FREE, 8'd42, '0);
		queue_request(pfa_pkg::OP_FREE, 8'd9, '0);
		queue_request(pfa_pkg::OP_ALLOC, 8'd1, 32'(NFRAMES * PG));
		queue_request(pfa_pkg::OP_FREE, 8'd1, '0);
		queue_request(pfa_pkg::OP_FREE, 8'd1, '0);
		queue_request(pfa_pkg::OP_ALLOC, 8'd3, 32'(8 * PG));
		wait_idle();
		// frames above the new count still go back on free
		write_reg(pfa_pkg::CFG_FRAME_COUNT, 17'd4);
		queue_request(pfa_pkg::OP_FREE, 8'd3, '0);
		queue_request(pfa_pkg::OP_ALLOC, 8'd4, 32'(4 * PG));
		queue_request(pfa_pkg::OP_ALLOC, 8'd5, 32'd1);
		queue_request(pfa_pkg::OP_FREE, 8'd4, '0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin fc = 0; psz = 1; end
				1: begin fc = 1; psz = 0; end
				2: begin fc = 127; psz = 17'h1FFFF; end
				3: begin fc = NFRAMES; psz = 65536; end
				default: begin
					case ($urandom_range(0, 3))
						0: psz = $urandom_range(1, 16);
						1: psz = $urandom_range(512, 8192);
						2: psz = $urandom_range(60000, 65536);
						default: psz = $urandom_range(0, 17'h1FFFF);
					endcase
					fc = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 127) :
						$urandom_range(1, NFRAMES);
				end
			endcase
			ps_eff = (psz == 0) ? 1 : psz;
			for (int k = 0; k < 8; k++) pool[k] = 8'($urandom());
			wait_idle();
			if (p % 3 == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 17'($urandom()));
			write_reg(pfa_pkg::CFG_FRAME_COUNT, {10'($urandom()), 7'(fc)});
			write_reg(pfa_pkg::CFG_PAGE_SIZE, 17'(psz));
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				r = $urandom_range(0, 99);
				who = pool[$urandom_range(0, 7)];
				if (r < 50)
					queue_request(pfa_pkg::OP_ALLOC, who,
						bytes_for_pages($urandom_range(0, 6), ps_eff));
				else if (r < 58)
					queue_request(pfa_pkg::OP_ALLOC, who,
						bytes_for_pages($urandom_range(7, 70), ps_eff));
				else if (r < 63)
					queue_request(pfa_pkg::OP_ALLOC, 8'($urandom()), $urandom());
				else if (r < 90)
					queue_request(pfa_pkg::OP_FREE, who, $urandom());
				else
					queue_request(pfa_pkg::OP_FREE, 8'($urandom()), $urandom());
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d register writes",
			n_requests, n_results, n_cfg);
		$display("%0d frames granted, %0d refused for space, %0d for unknown process",
			n_granted, n_nospace, n_noproc);
		if (n_errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/pfa_pkg.sv
rtl/pfa_div.sv
rtl/pfa_owner_mem.sv
rtl/pfa_known_mem.sv
rtl/paged_frame_allocator.sv
test/testbench.sv
